>>> hw/rtl/knn_pkg.sv
// shared types and constants for the k-nearest-neighbour selector
// no dependencies
package knn_pkg;

    localparam int NUM_AXES   = 3;
    localparam int POS_W      = 24;
    localparam int CNT_W      = 6;
    localparam int PIDX_W     = 32;
    localparam int DIST_W     = 50;
    localparam int SLOT_FW    = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 144;

    typedef logic signed [POS_W-1:0] t_pos;
    typedef logic [POS_W-1:0]        t_absdiff;
    typedef logic [DIST_W-1:0]       t_dist;
    typedef logic [PIDX_W-1:0]       t_pidx;

    // one kept neighbour as stored in the slot memory
    typedef struct packed {
        t_dist dsq;
        t_pidx pidx;
    } t_slot_entry;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_QUERY_X        = 2'd0;
    localparam t_cfg_idx CFG_QUERY_Y        = 2'd1;
    localparam t_cfg_idx CFG_QUERY_Z        = 2'd2;
    localparam t_cfg_idx CFG_NEIGHBOR_COUNT = 2'd3;

    localparam logic [CNT_W-1:0] NEIGHBOR_COUNT_RST = 6'd32;

endpackage

>>> hw/rtl/knn_ram.sv
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module knn_ram #(
    parameter int WIDTH = 82,
    parameter int DEPTH = 32
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/k_nearest_neighbor_select.sv
// k-nearest-neighbour selector top level: distance unit, slot memory and sequencer
// depends on knn_pkg and knn_ram
//
// Particles stream in as signed Q8.16 positions; the block keeps the neighbor_count
// nearest to the query point by squared distance, in a slot memory of MAX_SLOTS
// entries. A particle is not taken while the last one is still being processed:
// the single 24x24 squaring multiplier is used once per axis. When a particle
// replaces the current worst slot, the slots are rescanned through the memory read
// port, one per cycle, before the next particle is taken.
// On a particle with tlast, the kept slots are read back in order, one result beat
// per cycle while the output is taken, after a set-up state (ST_EMIT_RD); the final beat
// carries tlast. The output register lets the next particle in while the last beat
// still waits. Configuration writes are always taken and must only happen while
// the block is idle.
module k_nearest_neighbor_select
    import knn_pkg::*;
#(
    parameter int MAX_SLOTS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // particle stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [S_TDATA_W-1:0]  i_s_axis_tdata,   // particle_x, particle_y, particle_z
    input  logic                  i_s_axis_tlast,   // last_particle
    // result stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // slot, neighbor_index, distance_sq, max_distance_sq, zero fill
    output logic [M_TDATA_W-1:0]  o_m_axis_tdata,
    output logic                  o_m_axis_tlast    // last_result
);

    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int KW     = CNT_W + 1;
    localparam int ENT_W  = $bits(t_slot_entry);
    localparam int PAD_W  = M_TDATA_W - SLOT_FW - PIDX_W - 2 * DIST_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ,
        ST_DECIDE,
        ST_SCAN,
        ST_EMIT_RD,
        ST_EMIT_LD
    } t_state;

    t_state r_state;

    t_pos             r_query [NUM_AXES];
    logic [CNT_W-1:0] r_ncount;

    t_absdiff           r_ad [NUM_AXES];
    logic [1:0]         r_axis;
    logic [2*POS_W-1:0] r_prod;
    t_dist              r_acc;
    logic               r_last;

    t_pidx             r_count;
    t_dist             r_worst_dist;
    logic [SLOT_W-1:0] r_worst_slot;

    logic [KW-1:0]     r_rd_idx;
    logic [KW-1:0]     r_cmp_idx;
    logic              r_cmp_vld;
    t_dist             r_best;
    logic [SLOT_W-1:0] r_best_idx;

    logic [KW-1:0] r_emit_idx;
    logic [KW-1:0] r_emit_last;

    logic               r_out_vld;
    logic [SLOT_FW-1:0] r_out_slot;
    t_pidx              r_out_pidx;
    t_dist              r_out_dist;
    t_dist              r_out_max;
    logic               r_out_last;

    t_absdiff           w_ad [NUM_AXES];
    logic [2*POS_W-1:0] w_sq;
    logic [KW-1:0]      w_k;
    t_dist              w_r2;
    t_dist              w_wdist;
    logic [SLOT_W-1:0]  w_wslot;
    logic               w_fill;
    logic               w_replace;
    logic               w_in_acc;
    logic               w_load;
    logic [KW-1:0]      w_emit_next;
    logic               w_upd;
    t_dist              w_nbest;
    logic [SLOT_W-1:0]  w_nbest_idx;

    logic              w_we;
    logic [SLOT_W-1:0] w_waddr;
    t_slot_entry       w_wdata;
    logic [SLOT_W-1:0] w_raddr;
    logic [ENT_W-1:0]  w_rdata;
    t_slot_entry       w_rd;

    knn_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rd = t_slot_entry'(w_rdata);

    // absolute coordinate differences straight off the input beat
    always_comb begin
        logic signed [POS_W:0] d;
        logic signed [POS_W:0] p;
        logic signed [POS_W:0] q;
        for (int a = 0; a < NUM_AXES; a++) begin
            p = {i_s_axis_tdata[a*POS_W + POS_W-1], i_s_axis_tdata[a*POS_W +: POS_W]};
            q = {r_query[a][POS_W-1], r_query[a]};
            d = p - q;
            w_ad[a] = d[POS_W] ? t_absdiff'(-d) : t_absdiff'(d);
        end
    end

    assign w_sq = r_ad[r_axis] * r_ad[r_axis];

    // effective k: zero counts as one, clipped to the slot count
    always_comb begin
        if (r_ncount == '0) begin
            w_k = KW'(1);
        end else if ({1'b0, r_ncount} > KW'(MAX_SLOTS)) begin
            w_k = KW'(MAX_SLOTS);
        end else begin
            w_k = {1'b0, r_ncount};
        end
    end

    assign w_r2      = r_acc + DIST_W'(r_prod);
    // a fresh run starts from a cleared worst entry
    assign w_wdist   = (r_count == '0) ? '0 : r_worst_dist;
    assign w_wslot   = (r_count == '0) ? '0 : r_worst_slot;
    assign w_fill    = r_count < PIDX_W'(w_k);
    assign w_replace = !w_fill && (w_r2 < w_wdist);

    assign w_in_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign w_load      = !r_out_vld || i_m_axis_tready;
    assign w_emit_next = r_emit_idx + 1'b1;

    // rescan compare, first slot wins ties
    assign w_upd       = r_cmp_vld && (w_rd.dsq > r_best);
    assign w_nbest     = w_upd ? w_rd.dsq : r_best;
    assign w_nbest_idx = w_upd ? r_cmp_idx[SLOT_W-1:0] : r_best_idx;

    always_comb begin
        w_we         = 1'b0;
        w_waddr      = w_fill ? r_count[SLOT_W-1:0] : w_wslot;
        w_wdata.dsq  = w_r2;
        w_wdata.pidx = r_count;
        w_raddr      = '0;
        case (r_state)
            ST_DECIDE: begin
                w_we = w_fill || w_replace;
            end
            ST_SCAN: begin
                w_raddr = r_rd_idx[SLOT_W-1:0];
            end
            ST_EMIT_RD: begin
                w_raddr = r_emit_idx[SLOT_W-1:0];
            end
            ST_EMIT_LD: begin
                // hold the address while the output register is full
                w_raddr = w_load ? w_emit_next[SLOT_W-1:0] : r_emit_idx[SLOT_W-1:0];
            end
            default: begin
                w_raddr = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            for (int a = 0; a < NUM_AXES; a++) begin
                r_query[a] <= '0;
            end
            r_ncount     <= NEIGHBOR_COUNT_RST;
            r_count      <= '0;
            r_worst_dist <= '0;
            r_worst_slot <= '0;
            r_cmp_vld    <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_QUERY_X:        r_query[0] <= t_pos'(i_cfg_data);
                    CFG_QUERY_Y:        r_query[1] <= t_pos'(i_cfg_data);
                    CFG_QUERY_Z:        r_query[2] <= t_pos'(i_cfg_data);
                    CFG_NEIGHBOR_COUNT: r_ncount   <= i_cfg_data[CNT_W-1:0];
                    default:            r_ncount   <= r_ncount;
                endcase
            end

            // while emitting, the load below decides the output register
            if (r_out_vld && i_m_axis_tready && (r_state != ST_EMIT_LD)) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        for (int a = 0; a < NUM_AXES; a++) begin
                            r_ad[a] <= w_ad[a];
                        end
                        r_last  <= i_s_axis_tlast;
                        r_axis  <= '0;
                        r_state <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    // one axis squared per cycle, accumulated from the product register
                    r_prod <= w_sq;
                    r_acc  <= (r_axis == '0) ? '0 : r_acc + DIST_W'(r_prod);
                    if (r_axis == 2'd2) begin
                        r_state <= ST_DECIDE;
                    end else begin
                        r_axis <= r_axis + 1'b1;
                    end
                end
                ST_DECIDE: begin
                    r_count     <= r_count + 1'b1;
                    r_emit_idx  <= '0;
                    r_emit_last <= w_fill ? r_count[KW-1:0] : w_k - 1'b1;
                    if (w_fill) begin
                        if (w_r2 > w_wdist) begin
                            r_worst_dist <= w_r2;
                            r_worst_slot <= r_count[SLOT_W-1:0];
                        end else begin
                            r_worst_dist <= w_wdist;
                            r_worst_slot <= w_wslot;
                        end
                        r_state <= r_last ? ST_EMIT_RD : ST_IDLE;
                    end else if (w_replace) begin
                        r_best     <= '0;
                        r_best_idx <= w_wslot;
                        r_rd_idx   <= '0;
                        r_cmp_vld  <= 1'b0;
                        r_state    <= ST_SCAN;
                    end else begin
                        r_state <= r_last ? ST_EMIT_RD : ST_IDLE;
                    end
                end
                ST_SCAN: begin
                    // the read index has reached k by the time the last compare lands
                    if (r_rd_idx < w_k) begin
                        r_rd_idx  <= r_rd_idx + 1'b1;
                        r_cmp_idx <= r_rd_idx;
                        r_cmp_vld <= 1'b1;
                    end else begin
                        r_cmp_vld <= 1'b0;
                    end
                    r_best     <= w_nbest;
                    r_best_idx <= w_nbest_idx;
                    if (r_cmp_vld && (r_cmp_idx == w_k - 1'b1)) begin
                        r_worst_dist <= w_nbest;
                        r_worst_slot <= w_nbest_idx;
                        r_state      <= r_last ? ST_EMIT_RD : ST_IDLE;
                    end
                end
                ST_EMIT_RD: begin
                    r_state <= ST_EMIT_LD;
                end
                ST_EMIT_LD: begin
                    if (w_load) begin
                        r_out_vld  <= 1'b1;
                        r_out_slot <= r_emit_idx[SLOT_FW-1:0];
                        r_out_pidx <= w_rd.pidx;
                        r_out_dist <= w_rd.dsq;
                        r_out_max  <= r_worst_dist;
                        r_out_last <= (r_emit_idx == r_emit_last);
                        if (r_emit_idx == r_emit_last) begin
                            // end of run
                            r_count      <= '0;
                            r_worst_dist <= '0;
                            r_worst_slot <= '0;
                            r_state      <= ST_IDLE;
                        end else begin
                            r_emit_idx <= w_emit_next;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {{PAD_W{1'b0}}, r_out_max, r_out_dist, r_out_pidx, r_out_slot};
    assign o_m_axis_tlast  = r_out_last;

endmodule
